// ----- hw/rtl/lph_pkg.sv -----
// Package for the linear probing hash table: field widths, default parameters,
// command and status codes, and the structs between controller and datapath.
// No dependencies.
package lph_pkg;

   localparam int DEF_CAPACITY   = 1021;
   localparam int DEF_KEY_BITS   = 32;
   localparam int DEF_VALUE_BITS = 32;

   localparam int CMD_W   = 3;
   localparam int HASH_W  = 31;
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 3;
   localparam int SLOT_W  = 10;
   localparam int COUNT_W = 10;
   localparam int MAXE_W  = 10;

   localparam logic [MAXE_W-1:0] MAX_ENTRIES_RESET = 10'd714;

   // The home slot comes from a reciprocal multiplication of the 32-bit tag.
   localparam int TAG_W      = 32;
   localparam int HASH_STEPS = 3;
   localparam int HSTEP_W    = $clog2(HASH_STEPS);

   localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FIND    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

   localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd1;
   localparam logic [STAT_W-1:0] ST_REPLACED  = 3'd2;
   localparam logic [STAT_W-1:0] ST_FOUND     = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;
   localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd5;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd6;
   localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd7;

   typedef struct packed {
      logic              load;
      logic              clr_init;
      logic              clr_write;
      logic              hash_step;
      logic              probe_read;
      logic              probe_next;
      logic              entry_write;
      logic              count_inc;
      logic              shift_init;
      logic              shift_read;
      logic              shift_move;
      logic              shift_end;
      logic              finish;
      logic [STAT_W-1:0] res_status;
      logic              res_slot;
      logic              res_found;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             hash_done;
      logic             clr_last;
      logic             empty;
      logic             match;
      logic             probe_last;
      logic             room;
      logic             shift_last;
      logic             stays;
   } dp_stat_type;

endpackage

// ----- hw/rtl/lph_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/lph_ctrl.sv -----
// Controller state machine of the hash table: sequences clearing, home slot
// computation, probing and backward shift. Depends on lph_pkg.
module lph_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lph_pkg::CMD_W-1:0]  command,
   input  lph_pkg::dp_stat_type       stat,
   output lph_pkg::ctrl_cmd_type      ctl,
   output logic                       busy,
   output logic                       rsp_valid
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_HASH,
      S_PRD,
      S_PCHK,
      S_SRD,
      S_SCHK
   } state_type;

   state_type state_ff, state_in;
   logic      respond_ff, respond_in;
   logic      rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      respond_in = respond_ff;
      ctl        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               if (command == lph_pkg::CMD_CLEAR) begin
                  ctl.clr_init = 1'b1;
                  respond_in   = 1'b1;
                  state_in     = S_CLEAR;
               end else if (command == lph_pkg::CMD_INSERT || command == lph_pkg::CMD_REPLACE ||
                            command == lph_pkg::CMD_FIND || command == lph_pkg::CMD_REMOVE) begin
                  state_in = S_HASH;
               end else begin
                  ctl.finish     = 1'b1;
                  ctl.res_status = lph_pkg::ST_NOT_FOUND;
               end
            end
         end
         S_CLEAR: begin
            ctl.clr_write = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
               if (respond_ff) begin
                  ctl.finish     = 1'b1;
                  ctl.res_status = lph_pkg::ST_CLEARED;
               end
               respond_in = 1'b0;
            end
         end
         S_HASH: begin
            ctl.hash_step = 1'b1;
            if (stat.hash_done) begin
               state_in = S_PRD;
            end
         end
         S_PRD: begin
            ctl.probe_read = 1'b1;
            state_in       = S_PCHK;
         end
         S_PCHK: begin
            priority if (stat.empty) begin
               ctl.finish = 1'b1;
               state_in   = S_IDLE;
               if (stat.cmd == lph_pkg::CMD_INSERT || stat.cmd == lph_pkg::CMD_REPLACE) begin
                  if (stat.room) begin
                     ctl.entry_write = 1'b1;
                     ctl.count_inc   = 1'b1;
                     ctl.res_status  = lph_pkg::ST_INSERTED;
                     ctl.res_slot    = 1'b1;
                  end else begin
                     ctl.res_status = lph_pkg::ST_FULL;
                  end
               end else begin
                  ctl.res_status = lph_pkg::ST_NOT_FOUND;
               end
            end else if (stat.match) begin
               if (stat.cmd == lph_pkg::CMD_REMOVE) begin
                  ctl.shift_init = 1'b1;
                  state_in       = S_SRD;
               end else begin
                  ctl.finish   = 1'b1;
                  ctl.res_slot = 1'b1;
                  state_in     = S_IDLE;
                  if (stat.cmd == lph_pkg::CMD_REPLACE) begin
                     ctl.entry_write = 1'b1;
                     ctl.res_status  = lph_pkg::ST_REPLACED;
                  end else if (stat.cmd == lph_pkg::CMD_FIND) begin
                     ctl.res_found  = 1'b1;
                     ctl.res_status = lph_pkg::ST_FOUND;
                  end else begin
                     ctl.res_status = lph_pkg::ST_PRESENT;
                  end
               end
            end else if (stat.probe_last) begin
               ctl.finish = 1'b1;
               state_in   = S_IDLE;
               if (stat.cmd == lph_pkg::CMD_INSERT || stat.cmd == lph_pkg::CMD_REPLACE) begin
                  ctl.res_status = lph_pkg::ST_FULL;
               end else begin
                  ctl.res_status = lph_pkg::ST_NOT_FOUND;
               end
            end else begin
               ctl.probe_next = 1'b1;
               state_in       = S_PRD;
            end
         end
         S_SRD: begin
            if (stat.shift_last) begin
               ctl.shift_end  = 1'b1;
               ctl.finish     = 1'b1;
               ctl.res_status = lph_pkg::ST_REMOVED;
               ctl.res_slot   = 1'b1;
               state_in       = S_IDLE;
            end else begin
               ctl.shift_read = 1'b1;
               state_in       = S_SCHK;
            end
         end
         S_SCHK: begin
            if (stat.empty) begin
               ctl.shift_end  = 1'b1;
               ctl.finish     = 1'b1;
               ctl.res_status = lph_pkg::ST_REMOVED;
               ctl.res_slot   = 1'b1;
               state_in       = S_IDLE;
            end else begin
               ctl.shift_move = !stat.stays;
               state_in       = S_SRD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Reset starts with a sweep that empties every slot, without a result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         respond_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         respond_ff   <= respond_in;
         rsp_valid_ff <= ctl.finish;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/lph_dpath.sv -----
// Datapath of the hash table: request registers, slot memory, home slot
// remainder unit, probe and shift indexes, entry count and result registers.
// Depends on lph_pkg and lph_ram.
module lph_dpath #(
   parameter int CAPACITY   = lph_pkg::DEF_CAPACITY,
   parameter int KEY_BITS   = lph_pkg::DEF_KEY_BITS,
   parameter int VALUE_BITS = lph_pkg::DEF_VALUE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lph_pkg::ctrl_cmd_type        ctl,
   output lph_pkg::dp_stat_type         stat,
   input  logic [lph_pkg::CMD_W-1:0]    req_command,
   input  logic [lph_pkg::HASH_W-1:0]   req_hash,
   input  logic [lph_pkg::KEY_W-1:0]    req_key,
   input  logic [lph_pkg::VALUE_W-1:0]  req_value,
   input  logic                         csr_write_enable,
   input  logic [lph_pkg::MAXE_W-1:0]   csr_write_data,
   output logic [lph_pkg::STAT_W-1:0]   rsp_status,
   output logic [lph_pkg::VALUE_W-1:0]  rsp_found_value,
   output logic [lph_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [lph_pkg::COUNT_W-1:0]  rsp_entry_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int HW = lph_pkg::HASH_W;
   localparam int TW = lph_pkg::TAG_W;
   // Memory word: occupied bit, hash, home slot, key, payload.
   localparam int VAL_LO  = 0;
   localparam int KEY_LO  = VALUE_BITS;
   localparam int HOME_LO = KEY_LO + KEY_BITS;
   localparam int HASH_LO = HOME_LO + AW;
   localparam int OCC_BIT = HASH_LO + HW;
   localparam int WORD_W  = OCC_BIT + 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
   // Reciprocal of the capacity, rounded up, scaled by 2^(TW + AW).
   localparam int RCP_W  = TW + 1;
   localparam int RCP_SH = TW + AW;
   localparam int PROD_W = TW + RCP_W;
   localparam int QUOT_W = PROD_W - RCP_SH;
   localparam longint RCP_VAL =
      ((longint'(1) << RCP_SH) + longint'(CAPACITY) - longint'(1)) / longint'(CAPACITY);
   localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_VAL);

   logic [lph_pkg::CMD_W-1:0]   cmd_ff;
   logic [HW-1:0]               hash_ff;
   logic [KEY_BITS-1:0]         key_ff;
   logic [VALUE_BITS-1:0]       val_ff;
   logic [TW-1:0]               hsh_ff;
   logic [PROD_W-1:0]           prod_ff;
   logic [TW-1:0]               qc_ff;
   logic [QUOT_W-1:0]           quot;
   logic [TW-1:0]               diff;
   logic [AW-1:0]               rem_in;
   logic [lph_pkg::HSTEP_W-1:0] step_ff;
   logic [AW-1:0]               home_ff;
   logic [AW-1:0]               idx_ff;
   logic [AW-1:0]               n_ff;
   logic [AW-1:0]               hole_ff;
   logic [AW-1:0]               j_ff, j_next;
   logic [AW-1:0]               m_ff;
   logic [CW-1:0]               count_ff;
   logic [lph_pkg::MAXE_W-1:0]  max_entries_ff;
   logic [lph_pkg::STAT_W-1:0]  status_ff;
   logic [lph_pkg::VALUE_W-1:0] found_ff;
   logic [lph_pkg::SLOT_W-1:0]  slot_ff;

   logic              we;
   logic [AW-1:0]     waddr, raddr;
   logic [WORD_W-1:0] wdata, rdata;

   logic                  rd_occ;
   logic [HW-1:0]         rd_hash;
   logic [AW-1:0]         rd_home;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_val;

   assign rd_occ  = rdata[OCC_BIT];
   assign rd_hash = rdata[HASH_LO +: HW];
   assign rd_home = rdata[HOME_LO +: AW];
   assign rd_key  = rdata[KEY_LO +: KEY_BITS];
   assign rd_val  = rdata[VAL_LO +: VALUE_BITS];

   // The scaled reciprocal gives the exact quotient for every 32-bit tag, so the
   // remainder needs no correction. Product and quotient times capacity are
   // registered; the difference is combinational and registered as the home slot.
   assign quot   = prod_ff[RCP_SH +: QUOT_W];
   assign diff   = hsh_ff - qc_ff;
   assign rem_in = diff[AW-1:0];

   assign j_next = (j_ff == LAST_SLOT) ? '0 : j_ff + 1'b1;

   always_comb begin
      we    = 1'b0;
      waddr = idx_ff;
      wdata = '0;
      raddr = idx_ff;
      if (ctl.shift_read) begin
         raddr = j_next;
      end
      priority if (ctl.clr_write) begin
         we = 1'b1;
      end else if (ctl.entry_write) begin
         we    = 1'b1;
         wdata = {1'b1, hash_ff, home_ff, key_ff, val_ff};
      end else if (ctl.shift_move) begin
         we    = 1'b1;
         waddr = hole_ff;
         wdata = rdata;
      end else if (ctl.shift_end) begin
         we    = 1'b1;
         waddr = hole_ff;
      end
   end

   lph_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      stat            = '0;
      stat.cmd        = cmd_ff;
      stat.hash_done  = (step_ff == lph_pkg::HSTEP_W'(lph_pkg::HASH_STEPS - 1));
      stat.clr_last   = (idx_ff == LAST_SLOT);
      stat.empty      = !rd_occ;
      stat.match      = rd_occ && (rd_hash == hash_ff) && (rd_key == key_ff);
      stat.probe_last = (n_ff == LAST_SLOT);
      stat.room       = (32'(count_ff) < 32'(max_entries_ff));
      stat.shift_last = (m_ff == LAST_SLOT);
      // The moved-from entry stays when its home lies cyclically in (hole, j].
      if (hole_ff <= j_ff) begin
         stat.stays = (rd_home > hole_ff) && (rd_home <= j_ff);
      end else begin
         stat.stays = (rd_home > hole_ff) || (rd_home <= j_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff         <= '0;
         count_ff       <= '0;
         max_entries_ff <= lph_pkg::MAX_ENTRIES_RESET;
      end else begin
         if (csr_write_enable) begin
            max_entries_ff <= csr_write_data;
         end
         if (ctl.clr_init) begin
            idx_ff   <= '0;
            count_ff <= '0;
         end
         if (ctl.clr_write) begin
            idx_ff <= (idx_ff == LAST_SLOT) ? '0 : idx_ff + 1'b1;
         end
         if (ctl.hash_step) begin
            idx_ff <= rem_in;
         end
         if (ctl.probe_next) begin
            idx_ff <= (idx_ff == LAST_SLOT) ? '0 : idx_ff + 1'b1;
         end
         if (ctl.count_inc) begin
            count_ff <= count_ff + 1'b1;
         end
         if (ctl.shift_end && count_ff != '0) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff  <= req_command;
         hash_ff <= req_hash;
         key_ff  <= KEY_BITS'(req_key);
         val_ff  <= VALUE_BITS'(req_value);
         hsh_ff  <= {1'b1, req_hash};
         step_ff <= '0;
      end
      if (ctl.hash_step) begin
         prod_ff <= PROD_W'(hsh_ff) * PROD_W'(RCP);
         qc_ff   <= TW'(quot) * TW'(CAPACITY);
         step_ff <= step_ff + 1'b1;
         home_ff <= rem_in;
         n_ff    <= '0;
      end
      if (ctl.probe_next) begin
         n_ff <= n_ff + 1'b1;
      end
      if (ctl.shift_init) begin
         hole_ff <= idx_ff;
         j_ff    <= idx_ff;
         m_ff    <= '0;
      end
      if (ctl.shift_read) begin
         j_ff <= j_next;
         m_ff <= m_ff + 1'b1;
      end
      if (ctl.shift_move) begin
         hole_ff <= j_ff;
      end
      if (ctl.finish) begin
         status_ff <= ctl.res_status;
         found_ff  <= ctl.res_found ? lph_pkg::VALUE_W'(rd_val) : '0;
         slot_ff   <= ctl.res_slot ? lph_pkg::SLOT_W'(idx_ff) : '0;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_found_value = found_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_entry_count = lph_pkg::COUNT_W'(count_ff);

endmodule

// ----- hw/rtl/linear_probe_hash_table.sv -----
// Linear probing hash table. A request's result shows after the remainder unit
// has formed the home slot and each slot probed has been read from the registered
// slot memory and checked; a remove goes on to read and check each slot scanned
// after the match, the empty slot that ends the chain included. One request is in
// work at a time. Clear sweeps all CAPACITY slots; an unknown command is answered
// straight from idle. After reset the block sweeps all CAPACITY slots empty, busy high.
module linear_probe_hash_table #(
   parameter int CAPACITY   = lph_pkg::DEF_CAPACITY,
   parameter int KEY_BITS   = lph_pkg::DEF_KEY_BITS,
   parameter int VALUE_BITS = lph_pkg::DEF_VALUE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [lph_pkg::CMD_W-1:0]    req_command,
   input  logic [lph_pkg::HASH_W-1:0]   req_hash,
   input  logic [lph_pkg::KEY_W-1:0]    req_key,
   input  logic [lph_pkg::VALUE_W-1:0]  req_value,
   output logic                         rsp_valid,
   output logic [lph_pkg::STAT_W-1:0]   rsp_status,
   output logic [lph_pkg::VALUE_W-1:0]  rsp_found_value,
   output logic [lph_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [lph_pkg::COUNT_W-1:0]  rsp_entry_count,
   input  logic                         csr_write_enable,
   input  logic [lph_pkg::MAXE_W-1:0]   csr_write_data
);

   lph_pkg::ctrl_cmd_type ctl;
   lph_pkg::dp_stat_type  stat;

   lph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .command   (req_command),
      .stat      (stat),
      .ctl       (ctl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   lph_dpath #(
      .CAPACITY   (CAPACITY),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .req_command      (req_command),
      .req_hash         (req_hash),
      .req_key          (req_key),
      .req_value        (req_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_status       (rsp_status),
      .rsp_found_value  (rsp_found_value),
      .rsp_slot         (rsp_slot),
      .rsp_entry_count  (rsp_entry_count)
   );

endmodule

// ----- hw/rtl/lph_checker.sv -----
// Port-level checker for the hash table, bound to the top level.
// Depends on lph_pkg and linear_probe_hash_table.
module lph_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [lph_pkg::CMD_W-1:0]    req_command,
   input logic                         rsp_valid,
   input logic [lph_pkg::STAT_W-1:0]   rsp_status,
   input logic [lph_pkg::VALUE_W-1:0]  rsp_found_value,
   input logic [lph_pkg::SLOT_W-1:0]   rsp_slot,
   input logic [lph_pkg::COUNT_W-1:0]  rsp_entry_count
);

   // The block is sweeping the memory in the cycle after reset.
   a_busy_after_reset: assert property (@(posedge clock)
      $past(reset) |-> busy)
      else $error("busy low right after reset");

   a_unknown_cmd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command > lph_pkg::CMD_CLEAR) |=>
      (rsp_valid && rsp_status == lph_pkg::ST_NOT_FOUND && rsp_slot == '0))
      else $error("unknown command not answered next cycle as not found");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == lph_pkg::CMD_CLEAR) |=> (busy && !rsp_valid))
      else $error("clear transaction did not start a sweep");

   a_cleared_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == lph_pkg::ST_CLEARED) |-> (rsp_entry_count == '0))
      else $error("entry count not zero after clear");

   a_found_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != lph_pkg::ST_FOUND) |-> (rsp_found_value == '0))
      else $error("found value non-zero on a result that is not a hit");

endmodule

bind linear_probe_hash_table lph_checker u_lph_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_command     (req_command),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_found_value (rsp_found_value),
   .rsp_slot        (rsp_slot),
   .rsp_entry_count (rsp_entry_count)
);
